### rtl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define SQB_ASSERT_IMPL(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define SQB_ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

### rtl/sqb_pkg.sv
package sqb_pkg;
    localparam int MaxQuads = 1024;
    localparam int MaxSlots = 32;
    localparam int SlotW = 5;
    localparam int CntW = 6;
    localparam int CurW = 11;

    typedef enum logic [1:0] {
        MODE_QUAD = 2'd0, MODE_CIRCLE = 2'd1, MODE_FLUSH = 2'd2, MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        FS_IDLE, FS_SEARCH, FS_PUSH
    } fstate_t;

    typedef enum logic [2:0] {
        BS_IDLE, BS_MUL, BS_ROT, BS_EMIT
    } bstate_t;

    localparam logic [0:0] REG_SLOT_LIMIT = 1'b0;
    localparam logic [0:0] REG_QUAD_LIMIT = 1'b1;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic [15:0]        angle;
        logic [31:0]        color;
        logic               flip_u;
        logic               flip_v;
        logic               circle;
        logic [SlotW-1:0]   slot;
        logic [11:0]        vbase;
        logic               flushed;
    } job_t;

    function automatic logic [16:0] qsine(input logic [6:0] i);
        logic [16:0] t [0:64];
        t = '{17'd0, 17'd1608, 17'd3216, 17'd4821, 17'd6424, 17'd8022, 17'd9616,
              17'd11204, 17'd12785, 17'd14359, 17'd15924, 17'd17479, 17'd19024,
              17'd20557, 17'd22078, 17'd23586, 17'd25079, 17'd26558, 17'd28020,
              17'd29466, 17'd30893, 17'd32302, 17'd33692, 17'd35061, 17'd36410,
              17'd37736, 17'd39040, 17'd40320, 17'd41576, 17'd42806, 17'd44011,
              17'd45190, 17'd46341, 17'd47464, 17'd48559, 17'd49624, 17'd50660,
              17'd51665, 17'd52639, 17'd53581, 17'd54491, 17'd55368, 17'd56212,
              17'd57022, 17'd57798, 17'd58538, 17'd59244, 17'd59914, 17'd60547,
              17'd61145, 17'd61705, 17'd62228, 17'd62714, 17'd63162, 17'd63572,
              17'd63944, 17'd64277, 17'd64571, 17'd64827, 17'd65043, 17'd65220,
              17'd65358, 17'd65457, 17'd65516, 17'd65536};
        return (i > 7'd64) ? t[64] : t[i];
    endfunction

    // interpolated sine, Q16 signed
    function automatic logic signed [17:0] sine_q16(input logic [15:0] ang);
        logic [14:0] r;
        logic [16:0] a;
        logic [16:0] b;
        logic [24:0] p;
        logic [16:0] s;
        r = ang[14] ? (15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
        a = qsine(r[14:8]);
        b = qsine(r[14:8] + 7'd1);
        p = (b - a) * r[7:0];
        s = (r[14:8] >= 7'd64) ? 17'd65536 : a + p[24:8];
        return ang[15] ? -$signed({1'b0, s}) : $signed({1'b0, s});
    endfunction
endpackage

### rtl/sqb_front.sv
// accepts items, resolves batch cursor and texture slot
module sqb_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [5:0]            slot_limit,
    input  logic [10:0]           quad_limit,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_mode,
    input  logic [31:0]           s_pos_x,
    input  logic [31:0]           s_pos_y,
    input  logic [31:0]           s_scale_x,
    input  logic [31:0]           s_scale_y,
    input  logic [15:0]           s_angle,
    input  logic [31:0]           s_color_rgba,
    input  logic [15:0]           s_texture_id,
    input  logic                  s_flip_u,
    input  logic                  s_flip_v,
    output logic                  job_valid,
    input  logic                  job_ready,
    output sqb_pkg::job_t         job
);
    sqb_pkg::fstate_t state_reg, state_next;
    logic [15:0] table_mem [0:sqb_pkg::MaxSlots-1];
    logic [sqb_pkg::CntW-1:0] count_reg;
    logic [sqb_pkg::CurW-1:0] cursor_reg;
    logic [sqb_pkg::CntW-1:0] idx_reg;
    logic [15:0] rd_reg;
    logic [15:0] id_reg;
    logic        quad_reg;
    sqb_pkg::job_t job_reg;
    logic [5:0]  lim_s;
    logic [10:0] lim_q;
    logic        acc, draw, full;

    assign lim_s = (slot_limit == 6'd0) ? 6'd1 :
                   (slot_limit > 6'(sqb_pkg::MaxSlots)) ? 6'(sqb_pkg::MaxSlots) : slot_limit;
    assign lim_q = (quad_limit == 11'd0) ? 11'd1 :
                   (quad_limit > 11'(sqb_pkg::MaxQuads)) ? 11'(sqb_pkg::MaxQuads) :
                   quad_limit;
    assign s_ready = (state_reg == sqb_pkg::FS_IDLE);
    assign acc = s_valid && s_ready;
    assign draw = (s_mode == sqb_pkg::MODE_QUAD) || (s_mode == sqb_pkg::MODE_CIRCLE);
    assign full = ({1'b0, cursor_reg} + 12'd1) > {1'b0, lim_q};
    assign job = job_reg;
    assign job_valid = (state_reg == sqb_pkg::FS_PUSH);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sqb_pkg::FS_IDLE: begin
                if (acc && draw) state_next = sqb_pkg::FS_SEARCH;
            end
            sqb_pkg::FS_SEARCH: begin
                if (!quad_reg || id_reg == 16'd0 || idx_reg >= count_reg ||
                    (idx_reg > 6'd1 && rd_reg == id_reg) ||
                    idx_reg == 6'(sqb_pkg::MaxSlots))
                    state_next = sqb_pkg::FS_PUSH;
            end
            sqb_pkg::FS_PUSH: begin
                if (job_ready) state_next = sqb_pkg::FS_IDLE;
            end
            default: state_next = sqb_pkg::FS_IDLE;
        endcase
    end

    // search walks one table entry per cycle; rd_reg holds entry idx_reg-1
    // entry 0 is the white slot and never matches a texture id
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= sqb_pkg::FS_IDLE;
            count_reg  <= 6'd1;
            cursor_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (acc && s_mode == sqb_pkg::MODE_FLUSH) begin
                count_reg  <= 6'd1;
                cursor_reg <= '0;
            end
            if (acc && draw) begin
                job_reg.pos_x   <= s_pos_x;
                job_reg.pos_y   <= s_pos_y;
                job_reg.scale_x <= s_scale_x;
                job_reg.scale_y <= s_scale_y;
                job_reg.angle   <= s_angle;
                job_reg.color   <= s_color_rgba;
                job_reg.flip_u  <= s_flip_u;
                job_reg.flip_v  <= s_flip_v;
                job_reg.circle  <= s_mode[0];
                job_reg.slot    <= '0;
                job_reg.flushed <= full;
                job_reg.vbase   <= full ? 12'd0 : {cursor_reg[9:0], 2'b00};
                cursor_reg      <= full ? 11'd1 : cursor_reg + 11'd1;
                if (full) count_reg <= 6'd1;
                id_reg   <= s_texture_id;
                quad_reg <= !s_mode[0];
                idx_reg  <= 6'd0;
            end
            if (state_reg == sqb_pkg::FS_SEARCH && state_next == sqb_pkg::FS_SEARCH)
                idx_reg <= idx_reg + 6'd1;
            if (state_reg == sqb_pkg::FS_SEARCH && state_next == sqb_pkg::FS_PUSH &&
                quad_reg && id_reg != 16'd0) begin
                if (idx_reg > 6'd1 && idx_reg <= count_reg && rd_reg == id_reg)
                    job_reg.slot <= 5'(idx_reg - 6'd1);
                else if (count_reg < lim_s) begin
                    job_reg.slot <= count_reg[4:0];
                    count_reg    <= count_reg + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == sqb_pkg::FS_SEARCH && state_next == sqb_pkg::FS_PUSH &&
            quad_reg && id_reg != 16'd0 &&
            !(idx_reg > 6'd1 && idx_reg <= count_reg && rd_reg == id_reg) &&
            count_reg < lim_s)
            table_mem[count_reg[4:0]] <= id_reg;
        rd_reg <= table_mem[idx_reg[4:0]];
    end
endmodule

### rtl/sqb_queue.sv
// two-entry job queue between front and back
module sqb_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  sqb_pkg::job_t in_job,
    output logic          out_valid,
    input  logic          out_ready,
    output sqb_pkg::job_t out_job
);
    sqb_pkg::job_t q_reg [0:1];
    logic [1:0] cnt_reg;
    logic       rp_reg, wp_reg;
    logic       wr, rd;

    assign in_ready = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;
    assign out_job = q_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rp_reg  <= 1'b0;
            wp_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) q_reg[wp_reg] <= in_job;
    end
endmodule

### rtl/sqb_back.sv
// transforms one job into four corner vertices
module sqb_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    output logic                job_ready,
    input  sqb_pkg::job_t       job,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_vert_x,
    output logic signed [31:0]  m_vert_y,
    output logic                m_tex_u,
    output logic                m_tex_v,
    output logic [31:0]         m_vert_color,
    output logic                m_shape_kind,
    output logic [4:0]          m_tex_slot,
    output logic [11:0]         m_vertex_index,
    output logic                m_batch_flush,
    output logic                m_last
);
    sqb_pkg::bstate_t state_reg, state_next;
    sqb_pkg::job_t    j_reg;
    logic signed [17:0] sin_reg, cos_reg;
    logic signed [50:0] xc_reg, xs_reg, yc_reg, ys_reg;
    logic signed [51:0] dx_reg [0:1];
    logic signed [51:0] dy_reg [0:1];
    logic [1:0] k_reg;
    logic       sgx, sgy, u, v;
    logic signed [52:0] ex, ey;
    logic signed [35:0] rx, ry;
    logic signed [36:0] fx, fy;

    assign job_ready = (state_reg == sqb_pkg::BS_IDLE);
    assign m_valid = (state_reg == sqb_pkg::BS_EMIT);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sqb_pkg::BS_IDLE: if (job_valid) state_next = sqb_pkg::BS_MUL;
            sqb_pkg::BS_MUL:  state_next = sqb_pkg::BS_ROT;
            sqb_pkg::BS_ROT:  state_next = sqb_pkg::BS_EMIT;
            sqb_pkg::BS_EMIT: if (m_ready && k_reg == 2'd3) state_next = sqb_pkg::BS_IDLE;
            default: state_next = sqb_pkg::BS_IDLE;
        endcase
    end

    // corner signs (-,-) (+,-) (+,+) (-,+)
    assign sgx = (k_reg == 2'd0) || (k_reg == 2'd3);
    assign sgy = !k_reg[1];
    assign u = k_reg[0] ^ k_reg[1];
    assign v = k_reg[1];

    always_comb begin
        ex = sgx ? -53'(dx_reg[0]) : 53'(dx_reg[0]);
        ex = ex + (sgy ? 53'(dx_reg[1]) : -53'(dx_reg[1]));
        ey = sgx ? -53'(dy_reg[0]) : 53'(dy_reg[0]);
        ey = ey + (sgy ? -53'(dy_reg[1]) : 53'(dy_reg[1]));
        rx = 36'((ex + 53'sd65536) >>> 17);
        ry = 36'((ey + 53'sd65536) >>> 17);
        fx = 37'(rx) + 37'(j_reg.pos_x);
        fy = 37'(ry) + 37'(j_reg.pos_y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sqb_pkg::BS_IDLE;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == sqb_pkg::BS_IDLE && job_valid) begin
                j_reg   <= job;
                sin_reg <= sqb_pkg::sine_q16(job.angle);
                cos_reg <= sqb_pkg::sine_q16(job.angle + 16'd16384);
                k_reg   <= '0;
            end
            if (state_reg == sqb_pkg::BS_MUL) begin
                xc_reg <= j_reg.scale_x * cos_reg;
                xs_reg <= j_reg.scale_x * sin_reg;
                yc_reg <= j_reg.scale_y * cos_reg;
                ys_reg <= j_reg.scale_y * sin_reg;
            end
            if (state_reg == sqb_pkg::BS_ROT) begin
                // x part: sx*c, sy*s ; y part: sx*s, sy*c
                dx_reg[0] <= 52'(xc_reg);
                dx_reg[1] <= 52'(ys_reg);
                dy_reg[0] <= 52'(xs_reg);
                dy_reg[1] <= 52'(yc_reg);
            end
            if (state_reg == sqb_pkg::BS_EMIT && m_ready) k_reg <= k_reg + 2'd1;
        end
    end

    assign m_vert_x = (fx > 37'sd2147483647) ? 32'sh7fffffff :
                      (fx < -37'sd2147483648) ? 32'sh80000000 : fx[31:0];
    assign m_vert_y = (fy > 37'sd2147483647) ? 32'sh7fffffff :
                      (fy < -37'sd2147483648) ? 32'sh80000000 : fy[31:0];
    assign m_tex_u = u ^ j_reg.flip_u;
    assign m_tex_v = v ^ j_reg.flip_v;
    assign m_vert_color = j_reg.color;
    assign m_shape_kind = j_reg.circle;
    assign m_tex_slot = j_reg.slot;
    assign m_vertex_index = j_reg.vbase + {10'd0, k_reg};
    assign m_batch_flush = j_reg.flushed;
    assign m_last = (k_reg == 2'd3);
endmodule

### rtl/sprite_quad_batcher_top.sv
// sprite quad batcher: four corner vertices per draw transfer
// front: no new item until its job is pushed; textured quads also search the slot table
// back: loads the job, then MUL and ROT, then one vertex per cycle while m_ready is high
// flush transfers make no job; they reset the batch cursor and slot count
// synchronous active-low reset clears cursor, slot count and the queue;
// registers return to slot limit 16 and quad limit 1024
module sprite_quad_batcher_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_scale_x,
    input  logic signed [31:0] s_scale_y,
    input  logic [15:0]        s_angle,
    input  logic [31:0]        s_color_rgba,
    input  logic [15:0]        s_texture_id,
    input  logic               s_flip_u,
    input  logic               s_flip_v,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_vert_x,
    output logic signed [31:0] m_vert_y,
    output logic               m_tex_u,
    output logic               m_tex_v,
    output logic [31:0]        m_vert_color,
    output logic               m_shape_kind,
    output logic [4:0]         m_tex_slot,
    output logic [11:0]        m_vertex_index,
    output logic               m_batch_flush,
    output logic               m_last
);
    logic [5:0]  slot_lim_reg;
    logic [10:0] quad_lim_reg;
    logic        fj_valid, fj_ready, bj_valid, bj_ready;
    sqb_pkg::job_t fj, bj;

    assign pready = 1'b1;

    // register writes on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_lim_reg <= 6'd16;
            quad_lim_reg <= 11'd1024;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            if (paddr[2] == sqb_pkg::REG_SLOT_LIMIT) slot_lim_reg <= pwdata[5:0];
            else quad_lim_reg <= pwdata[10:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'b00) begin
            if (paddr[2] == sqb_pkg::REG_QUAD_LIMIT) prdata = {21'd0, quad_lim_reg};
            else prdata = {26'd0, slot_lim_reg};
        end
    end

    sqb_front u_front (
        .aclk, .aresetn,
        .slot_limit(slot_lim_reg), .quad_limit(quad_lim_reg),
        .s_valid, .s_ready, .s_mode, .s_pos_x, .s_pos_y, .s_scale_x, .s_scale_y,
        .s_angle, .s_color_rgba, .s_texture_id, .s_flip_u, .s_flip_v,
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    sqb_queue u_queue (
        .aclk, .aresetn,
        .in_valid(fj_valid), .in_ready(fj_ready), .in_job(fj),
        .out_valid(bj_valid), .out_ready(bj_ready), .out_job(bj)
    );

    sqb_back u_back (
        .aclk, .aresetn,
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
        .m_valid, .m_ready, .m_vert_x, .m_vert_y, .m_tex_u, .m_tex_v,
        .m_vert_color, .m_shape_kind, .m_tex_slot, .m_vertex_index,
        .m_batch_flush, .m_last
    );
endmodule

### rtl/sqb_checker.sv
`include "assert_macros.svh"
// port-level checks
module sqb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_last,
    input logic [11:0] m_vertex_index,
    input logic [4:0]  m_tex_slot,
    input logic        m_shape_kind,
    input logic        pready
);
    `SQB_ASSERT_IMPL(a_last_corner, aclk, aresetn, m_valid && m_last, m_vertex_index[1:0] == 2'd3)
    `SQB_ASSERT_IMPL(a_circle_slot, aclk, aresetn, m_valid && m_shape_kind, m_tex_slot == 5'd0)
    `SQB_ASSERT_NEXT(a_corner_step, aclk, aresetn, m_valid && m_ready && !m_last, m_valid && m_vertex_index[1:0] == $past(m_vertex_index[1:0]) + 2'd1)
    `SQB_ASSERT_IMPL(a_pready, aclk, aresetn, 1'b1, pready)
endmodule

bind sprite_quad_batcher_top sqb_checker u_sqb_checker (
    .aclk, .aresetn, .m_valid, .m_ready, .m_last, .m_vertex_index,
    .m_tex_slot, .m_shape_kind, .pready
);
